// File: rtl/core/arfp_pkg.sv
// Shared types and constants of the audio module reply-frame parser.
`default_nettype none

package arfp_pkg;

  // Fixed frame bytes.
  localparam logic [7:0] BYTE_HEADER  = 8'h7E;
  localparam logic [7:0] BYTE_VERSION = 8'hFF;
  localparam logic [7:0] BYTE_LENGTH  = 8'h06;
  localparam logic [7:0] BYTE_END     = 8'hEF;

  // Command codes of the reply frames.
  localparam logic [7:0] CMD_FINISHED_USB  = 8'h3C;
  localparam logic [7:0] CMD_FINISHED_CARD = 8'h3D;
  localparam logic [7:0] CMD_INSERTED      = 8'h3A;
  localparam logic [7:0] CMD_REMOVED       = 8'h3B;
  localparam logic [7:0] CMD_FEEDBACK_LO   = 8'h3E;
  localparam logic [7:0] CMD_ONLINE        = 8'h3F;
  localparam logic [7:0] CMD_ERROR         = 8'h40;
  localparam logic [7:0] CMD_ACK           = 8'h41;
  localparam logic [7:0] CMD_FEEDBACK_FIRST = 8'h42;
  localparam logic [7:0] CMD_FEEDBACK_GAP  = 8'h4A;
  localparam logic [7:0] CMD_FEEDBACK_LAST = 8'h4F;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned FIFO_DEPTH = 2;

  // Event kinds reported on the result channel.
  typedef enum logic [3:0] {
    EV_FINISHED  = 4'd0,
    EV_USB_ON    = 4'd1,
    EV_CARD_ON   = 4'd2,
    EV_USB_IN    = 4'd3,
    EV_CARD_IN   = 4'd4,
    EV_USB_OUT   = 4'd5,
    EV_CARD_OUT  = 4'd6,
    EV_ERROR     = 4'd7,
    EV_FEEDBACK  = 4'd8,
    EV_ACK       = 4'd9,
    EV_BAD_FRAME = 4'd10
  } event_kind_e;

  // Byte positions within a frame.
  typedef enum logic [3:0] {
    POS_HEADER   = 4'd0,
    POS_VERSION  = 4'd1,
    POS_LENGTH   = 4'd2,
    POS_COMMAND  = 4'd3,
    POS_ACK      = 4'd4,
    POS_PARAM_HI = 4'd5,
    POS_PARAM_LO = 4'd6,
    POS_CSUM_HI  = 4'd7,
    POS_CSUM_LO  = 4'd8,
    POS_END      = 4'd9
  } frame_pos_e;

  // One judged frame as handed from the front part to the back part.
  typedef struct packed {
    logic        bad;
    logic [7:0]  cmd;
    logic [15:0] par;
  } frame_rec_t;

endpackage

`default_nettype wire

// File: rtl/core/arfp_front.sv
// Front part: hunts for the header, checks each frame byte and the checksum.
`default_nettype none

module arfp_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rx_valid_i,
  output logic                      rx_stall_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output arfp_pkg::frame_rec_t      push_data_o
);
  import arfp_pkg::*;

  frame_pos_e  pos_q, pos_d;
  logic [10:0] sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] par_q, par_d;
  logic [15:0] csum_q, csum_d;
  logic        accept;
  logic [15:0] check;

  // A beat is taken whenever the queue has room for a possible record.
  assign rx_stall_o = full_i;
  assign accept     = rx_valid_i && !full_i;

  // The sum of bytes one to six plus the received checksum wraps to zero.
  assign check = 16'(sum_q) + csum_q;

  // Frame position register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HEADER;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Frame contents; these need no reset.
  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    cmd_q  <= cmd_d;
    par_q  <= par_d;
    csum_q <= csum_d;
  end

  // Next position, captured fields and the record pushed to the queue.
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    cmd_d       = cmd_q;
    par_d       = par_q;
    csum_d      = csum_q;
    push_o      = 1'b0;
    push_data_o = '{bad: 1'b1, cmd: 8'h00, par: 16'h0000};
    if (accept) begin
      case (pos_q)
        POS_HEADER: begin
          sum_d = '0;
          if (rx_byte_i == BYTE_HEADER) begin
            pos_d = POS_VERSION;
          end
        end
        POS_VERSION: begin
          sum_d = sum_q + 11'(rx_byte_i);
          if (rx_byte_i != BYTE_VERSION) begin
            push_o = 1'b1;
            pos_d  = POS_HEADER;
          end else begin
            pos_d = POS_LENGTH;
          end
        end
        POS_LENGTH: begin
          sum_d = sum_q + 11'(rx_byte_i);
          if (rx_byte_i != BYTE_LENGTH) begin
            push_o = 1'b1;
            pos_d  = POS_HEADER;
          end else begin
            pos_d = POS_COMMAND;
          end
        end
        POS_COMMAND: begin
          sum_d = sum_q + 11'(rx_byte_i);
          cmd_d = rx_byte_i;
          pos_d = POS_ACK;
        end
        POS_ACK: begin
          sum_d = sum_q + 11'(rx_byte_i);
          pos_d = POS_PARAM_HI;
        end
        POS_PARAM_HI: begin
          sum_d        = sum_q + 11'(rx_byte_i);
          par_d[15:8]  = rx_byte_i;
          pos_d        = POS_PARAM_LO;
        end
        POS_PARAM_LO: begin
          sum_d       = sum_q + 11'(rx_byte_i);
          par_d[7:0]  = rx_byte_i;
          pos_d       = POS_CSUM_HI;
        end
        POS_CSUM_HI: begin
          csum_d[15:8] = rx_byte_i;
          pos_d        = POS_CSUM_LO;
        end
        POS_CSUM_LO: begin
          csum_d[7:0] = rx_byte_i;
          pos_d       = POS_END;
        end
        POS_END: begin
          push_o = 1'b1;
          pos_d  = POS_HEADER;
          push_data_o.bad = (rx_byte_i != BYTE_END) || (check != 16'h0000);
          push_data_o.cmd = cmd_q;
          push_data_o.par = par_q;
        end
        default: begin
          // A position past the end restarts the hunt and drops the byte.
          pos_d = POS_HEADER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arfp_fifo.sv
// Short queue of judged frames between the front and back parts.
`default_nettype none

module arfp_fifo #(
  parameter int unsigned Depth = arfp_pkg::FIFO_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire arfp_pkg::frame_rec_t push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output arfp_pkg::frame_rec_t      pop_data_o
);
  import arfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_rec_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arfp_back.sv
// Back part: classifies judged frames by command and holds the result beat.
`default_nettype none

module arfp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  input  wire arfp_pkg::frame_rec_t rec_i,
  output logic                      pop_o,
  output logic                      event_valid_o,
  input  wire logic                 event_stall_i,
  output logic [3:0]                event_kind_o,
  output logic [7:0]                event_command_o,
  output logic [15:0]               event_parameter_o
);
  import arfp_pkg::*;

  logic        valid_q, valid_d;
  event_kind_e kind_q, kind_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] par_q, par_d;
  logic        out_free;
  logic        emit;
  event_kind_e kind;
  event_kind_e usb_kind, card_kind;
  logic        device;

  // The output register may load when empty or when its beat leaves now.
  assign out_free = !valid_q || !event_stall_i;
  assign pop_o    = !empty_i && out_free;

  // Command classification of the frame at the head of the queue.
  always_comb begin
    kind      = EV_BAD_FRAME;
    usb_kind  = EV_USB_ON;
    card_kind = EV_CARD_ON;
    device    = 1'b0;
    case (rec_i.cmd)
      CMD_FINISHED_USB, CMD_FINISHED_CARD: kind = EV_FINISHED;
      CMD_ONLINE: begin
        device    = 1'b1;
      end
      CMD_INSERTED: begin
        device    = 1'b1;
        usb_kind  = EV_USB_IN;
        card_kind = EV_CARD_IN;
      end
      CMD_REMOVED: begin
        device    = 1'b1;
        usb_kind  = EV_USB_OUT;
        card_kind = EV_CARD_OUT;
      end
      CMD_ERROR:       kind = EV_ERROR;
      CMD_ACK:         kind = EV_ACK;
      CMD_FEEDBACK_LO: kind = EV_FEEDBACK;
      default: begin
        // Feedback covers a range of codes with one hole in it.
        if (rec_i.cmd >= CMD_FEEDBACK_FIRST && rec_i.cmd <= CMD_FEEDBACK_LAST &&
            rec_i.cmd != CMD_FEEDBACK_GAP) begin
          kind = EV_FEEDBACK;
        end
      end
    endcase

    // Device events pick usb on bit 0, else card on bit 1, else nothing.
    emit = 1'b1;
    if (rec_i.bad) begin
      kind = EV_BAD_FRAME;
    end else if (device) begin
      if (rec_i.par[0]) begin
        kind = usb_kind;
      end else if (rec_i.par[1]) begin
        kind = card_kind;
      end else begin
        emit = 1'b0;
      end
    end
  end

  // Next contents of the output register.
  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    cmd_d   = cmd_q;
    par_d   = par_q;
    if (out_free) begin
      valid_d = pop_o && emit;
      kind_d  = kind;
      if (kind == EV_BAD_FRAME) begin
        cmd_d = 8'h00;
        par_d = 16'h0000;
      end else begin
        cmd_d = rec_i.cmd;
        par_d = rec_i.par;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output payload; it needs no reset.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    cmd_q  <= cmd_d;
    par_q  <= par_d;
  end

  assign event_valid_o     = valid_q;
  assign event_kind_o      = 4'(kind_q);
  assign event_command_o   = cmd_q;
  assign event_parameter_o = par_q;

endmodule

`default_nettype wire

// File: rtl/core/audio_module_reply_frame_parser.sv
// Top level of the audio module reply-frame parser.
//
//   Channel  Direction  Handshake                    Payload
//   rx       in         rx_valid_i / rx_stall_o      rx_byte_i
//   event    out        event_valid_o / event_stall_i
//                                                    event_kind_o, event_command_o,
//                                                    event_parameter_o
//
// A byte beat is taken every cycle while the frame queue has room.
// A result beat for the byte that ends or breaks a frame is built in order:
// the front part judges that byte and writes the queue when it accepts it,
// and the back part then loads the output register once that register is free.
// The output register loads whenever it is empty or its beat leaves, so the rate
// is one beat per cycle on both sides unless stalled; the queue depth sets how
// many results may wait while event_stall_i is high before rx_stall_o rises.
// Reset returns the parser to the header hunt and empties the queue and output.
`default_nettype none

module audio_module_reply_frame_parser #(
  parameter int unsigned FifoDepth = arfp_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             event_valid_o,
  input  wire logic        event_stall_i,
  output logic [3:0]       event_kind_o,
  output logic [7:0]       event_command_o,
  output logic [15:0]      event_parameter_o
);
  import arfp_pkg::*;

  logic       push, pop, full, empty;
  frame_rec_t push_data, pop_data;

  // Byte checking and frame assembly.
  arfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue of judged frames.
  arfp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  // Classification and result register.
  arfp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .rec_i             (pop_data),
    .pop_o             (pop),
    .event_valid_o     (event_valid_o),
    .event_stall_i     (event_stall_i),
    .event_kind_o      (event_kind_o),
    .event_command_o   (event_command_o),
    .event_parameter_o (event_parameter_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/arfp_checker.sv
// Port-level checks of the reply-frame parser and their binding to it.
`default_nettype none

module arfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        event_valid_o,
  input wire logic        event_stall_i,
  input wire logic [3:0]  event_kind_o,
  input wire logic [7:0]  event_command_o,
  input wire logic [15:0] event_parameter_o
);
  import arfp_pkg::*;

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_stall_i |=> event_valid_o)
    else $error("result beat dropped while stalled");

  // A bad frame carries no command and no parameter.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o == EV_BAD_FRAME |->
      event_command_o == 8'h00 && event_parameter_o == 16'h0000)
    else $error("bad frame with nonzero payload");

  // An acknowledge beat always carries the acknowledge command.
  a_ack_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o == EV_ACK |-> event_command_o == CMD_ACK)
    else $error("acknowledge kind with another command");

  // Usb device events need bit 0 of the parameter.
  a_usb_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && (event_kind_o == EV_USB_ON || event_kind_o == EV_USB_IN ||
                      event_kind_o == EV_USB_OUT) |-> event_parameter_o[0])
    else $error("usb event without usb bit");

  // Card device events need bit 1 and not bit 0.
  a_card_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && (event_kind_o == EV_CARD_ON || event_kind_o == EV_CARD_IN ||
                      event_kind_o == EV_CARD_OUT) |->
      event_parameter_o[1] && !event_parameter_o[0])
    else $error("card event with wrong device bits");

endmodule

bind audio_module_reply_frame_parser arfp_checker u_arfp_checker (.*);

`default_nettype wire
